[hdl/mpt_pkg.sv]
// Shared constants, types and controller states for the Mersenne primality tester.
package mpt_pkg;

  localparam int EXP_W            = 5;
  localparam int VAL_W            = 31;
  localparam int DIV_W            = (VAL_W + 2) / 2;
  localparam int SQ_W             = 2 * DIV_W;
  localparam int CNT_W            = $clog2(VAL_W);
  localparam int MAX_EXPONENT_DEF = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } rem_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

[hdl/mpt_rem.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module mpt_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  mpt_pkg::rem_cmd_t cmd,
  output mpt_pkg::rem_stat_t stat
);

  logic [mpt_pkg::VAL_W-1:0] shreg_r, shreg_nxt;
  logic [mpt_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [mpt_pkg::DIV_W-1:0] div_r, div_nxt;
  logic [mpt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [mpt_pkg::DIV_W:0]   trial;

  assign trial = {rem_r, shreg_r[mpt_pkg::VAL_W-1]};

  always_comb begin
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (cmd.start) begin
      shreg_nxt = cmd.dividend;
      rem_nxt   = '0;
      div_nxt   = cmd.divisor;
      cnt_nxt   = '0;
      run_nxt   = 1'b1;
    end else if (run_r) begin
      // remainder stays below the divisor, so the difference fits DIV_W bits
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = mpt_pkg::DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[mpt_pkg::DIV_W-1:0];
      end
      shreg_nxt = {shreg_r[mpt_pkg::VAL_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == mpt_pkg::CNT_W'(mpt_pkg::VAL_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

[hdl/mpt_ctrl.sv]
// Trial-division sequencer: forms 2^p - 1, steps divisors, tracks d*d incrementally.
module mpt_ctrl #(
  parameter int MAX_EXPONENT = mpt_pkg::MAX_EXPONENT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mpt_pkg::EXP_W-1:0] in_exponent,
  output logic                      busy,
  output mpt_pkg::rem_cmd_t         rem_cmd,
  input  mpt_pkg::rem_stat_t        rem_stat,
  output logic                      out_valid,
  output logic [mpt_pkg::VAL_W-1:0] out_mersenne_value,
  output logic                      out_is_prime
);

  localparam logic [mpt_pkg::VAL_W-1:0] ALL_ONES = '1;

  mpt_pkg::state_t state_r, state_nxt;

  logic [mpt_pkg::VAL_W-1:0] m_r, m_nxt;
  logic [mpt_pkg::DIV_W-1:0] d_r, d_nxt;
  logic [mpt_pkg::SQ_W-1:0]  sq_r, sq_nxt;
  logic                      valid_r, valid_nxt;
  logic                      prime_r, prime_nxt;

  logic [mpt_pkg::EXP_W-1:0] e_sat;
  logic [mpt_pkg::VAL_W-1:0] m_new;
  logic                      accept;
  logic                      small_val;
  logic                      sq_over;
  logic                      issue;
  logic                      finish;
  logic                      finish_prime;
  logic                      step;

  assign accept = start && (state_r == mpt_pkg::ST_IDLE);
  assign e_sat  = (in_exponent > mpt_pkg::EXP_W'(MAX_EXPONENT)) ?
                  mpt_pkg::EXP_W'(MAX_EXPONENT) : in_exponent;
  // shift by the full width leaves zero for p = 0
  assign m_new  = ALL_ONES >> (6'(mpt_pkg::VAL_W) - {1'b0, e_sat});

  assign small_val = (m_r < mpt_pkg::VAL_W'(2));
  assign sq_over   = (sq_r > {{(mpt_pkg::SQ_W-mpt_pkg::VAL_W){1'b0}}, m_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpt_pkg::ST_IDLE: begin
        if (start) state_nxt = mpt_pkg::ST_CHECK;
      end
      mpt_pkg::ST_CHECK: begin
        if (small_val || sq_over) state_nxt = mpt_pkg::ST_IDLE;
        else                      state_nxt = mpt_pkg::ST_DIVIDE;
      end
      mpt_pkg::ST_DIVIDE: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) state_nxt = mpt_pkg::ST_IDLE;
          else               state_nxt = mpt_pkg::ST_CHECK;
        end
      end
      default: state_nxt = mpt_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    issue        = 1'b0;
    finish       = 1'b0;
    finish_prime = 1'b0;
    step         = 1'b0;
    unique case (state_r)
      mpt_pkg::ST_IDLE: begin
      end
      mpt_pkg::ST_CHECK: begin
        if (small_val) begin
          finish = 1'b1;
        end else if (sq_over) begin
          finish       = 1'b1;
          finish_prime = 1'b1;
        end else begin
          issue = 1'b1;
        end
      end
      mpt_pkg::ST_DIVIDE: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) finish = 1'b1;
          else               step   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    m_nxt     = m_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    valid_nxt = finish;
    prime_nxt = prime_r;
    if (accept) begin
      m_nxt  = m_new;
      d_nxt  = mpt_pkg::DIV_W'(2);
      sq_nxt = mpt_pkg::SQ_W'(4);
    end else if (step) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_nxt  = d_r + 1'b1;
      sq_nxt = sq_r + mpt_pkg::SQ_W'({d_r, 1'b1});
    end
    if (finish) prime_nxt = finish_prime;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpt_pkg::ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign busy             = (state_r != mpt_pkg::ST_IDLE);
  assign rem_cmd.start    = issue;
  assign rem_cmd.dividend = m_r;
  assign rem_cmd.divisor  = d_r;

  assign out_valid          = valid_r;
  assign out_mersenne_value = m_r;
  assign out_is_prime       = prime_r;

endmodule

[hdl/mersenne_prime_test.sv]
// Top level of the Mersenne primality tester: sequencer plus serial remainder unit.
//
//   channel | ports                                        | handshake
//   input   | in_exponent                                  | start && !busy
//   result  | out_mersenne_value, out_is_prime             | out_valid, one cycle
//
// Each divisor passes through the check state, the serial remainder steps and the
// done strobe of the remainder unit. A prime 2^p - 1 is divided by every d from 2
// to floor(sqrt(2^p - 1)), a composite stops after its smallest factor and p below
// two finishes in the check state. Synchronous active low reset returns to idle and
// drops the strobe. The result shows for one cycle and cannot be stalled; a new
// start may be given in that same cycle.
module mersenne_prime_test #(
  parameter int MAX_EXPONENT = mpt_pkg::MAX_EXPONENT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mpt_pkg::EXP_W-1:0] in_exponent,
  output logic                      busy,
  output logic                      out_valid,
  output logic [mpt_pkg::VAL_W-1:0] out_mersenne_value,
  output logic                      out_is_prime
);

  mpt_pkg::rem_cmd_t  rem_cmd;
  mpt_pkg::rem_stat_t rem_stat;

  mpt_ctrl #(
    .MAX_EXPONENT(MAX_EXPONENT)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_exponent       (in_exponent),
    .busy              (busy),
    .rem_cmd           (rem_cmd),
    .rem_stat          (rem_stat),
    .out_valid         (out_valid),
    .out_mersenne_value(out_mersenne_value),
    .out_is_prime      (out_is_prime)
  );

  mpt_rem u_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (rem_cmd),
    .stat (rem_stat)
  );

endmodule

[hdl/mpt_checker.sv]
// Port-level checker for the Mersenne primality tester, bound to the top level.
module mpt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [mpt_pkg::VAL_W-1:0] out_mersenne_value,
  input logic                      out_is_prime
);

  // an accepted beat keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every finished item leaves busy with a strobe
  a_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mersenne_value < mpt_pkg::VAL_W'(2)) |-> !out_is_prime)
    else $error("value below two flagged prime");

endmodule

bind mersenne_prime_test mpt_checker u_mpt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_mersenne_value(out_mersenne_value),
  .out_is_prime      (out_is_prime)
);
